### hdl/edf_deadline_scheduler_core_assert.svh
// Assertion macros used by the scheduler checker.
`ifndef EDF_DEADLINE_SCHEDULER_CORE_ASSERT_SVH
`define EDF_DEADLINE_SCHEDULER_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define EDF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define EDF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hdl/edf_pkg.sv
// ----------------------------------------------------------------------------
// edf_pkg
// Shared types and codes of the deadline scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package edf_pkg;

    typedef enum logic [2:0] {
        EV_PREEMPT = 3'd0,
        EV_REMOVED = 3'd1,
        EV_FINISH  = 3'd2,
        EV_SUMMARY = 3'd3,
        EV_ACCEPT  = 3'd4,
        EV_DROP    = 3'd5
    } t_event_kind;

    typedef struct packed {
        logic [15:0] pid;
        logic [31:0] deadline;
        logic [31:0] arrived;
        logic [15:0] remaining;
        logic [15:0] full_burst;
    } t_job;

    typedef struct packed {
        logic shift;  // take neighbor's job
        logic load;   // take pushed job
    } t_cell_ctl;

endpackage

`default_nettype wire

### hdl/edf_cell.sv
// ----------------------------------------------------------------------------
// edf_cell
// One queue slot: shifts in its upper neighbor's job or loads a pushed job.
// ----------------------------------------------------------------------------
`default_nettype none

module edf_cell (
    input  wire               i_clk,
    input  edf_pkg::t_cell_ctl i_ctl,
    input  edf_pkg::t_job     i_push,
    input  edf_pkg::t_job     i_next,
    output edf_pkg::t_job     o_job
);

    edf_pkg::t_job r_job;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_job <= i_next;
        end else if (i_ctl.load) begin
            r_job <= i_push;
        end
    end

    assign o_job = r_job;

endmodule

`default_nettype wire

### hdl/edf_deadline_scheduler_core.sv
// ----------------------------------------------------------------------------
// edf_deadline_scheduler_core
// Preemptive earliest-deadline-first scheduler stepped one tick per tick item.
// ----------------------------------------------------------------------------
// Input channel (s_axis): tuser[0] = mode (0 arrival, 1 tick), tdata holds
// job_id, burst_len, due_tick. Output channel (m_axis): tuser = event kind,
// tdata = pid, span, totals; tlast marks the final result of an input item.
// Queue: a row of QUEUE_DEPTH cells in insertion order. Removing a slot
// shifts every cell above it down one place at once; a push
// loads the cell at the fill count.
// Arrival: one result (accepted or dropped).
// Tick: the pick is a scan over the cells, one cell per cycle. A tick
// runs the scan, take, check, execute and summary states, and each
// removed job adds another pick scan; an empty queue skips the scan.
// Results leave through a one-entry output register; the sequencer waits
// in place while that register is full and not being taken, so a stalled
// receiver only stretches the tick. Input is taken only when idle.
// Reset: empty queue, no running job, tick counter and totals at zero.
// ----------------------------------------------------------------------------
`default_nettype none

module edf_deadline_scheduler_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: job_id[15:0], burst_len[31:16], due_tick[63:32]
    input  wire  [63:0]  s_axis_tdata,
    // tuser: mode[0]
    input  wire  [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // tdata: event_pid[15:0], span_start[47:16], span_end[79:48],
    // wait_total[127:80], turnaround_total[175:128], done_count[207:176],
    // dropped_count[239:208]
    output logic [239:0] m_axis_tdata,
    // tuser: event_kind[2:0]
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [47:0] MAX48 = {48{1'b1}};

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_TAKE  = 6'b000100,
        S_CHECK = 6'b001000,
        S_EXEC  = 6'b010000,
        S_SUM   = 6'b100000
    } t_state;

    function automatic logic [47:0] sat48(input logic [47:0] a, input logic [31:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {17'b0, b};
        return (s >= {1'b0, MAX48}) ? MAX48 : s[47:0];
    endfunction

    function automatic logic [31:0] inc32(input logic [31:0] a);
        return (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
    endfunction

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_i, n_i;
    logic [IW-1:0]   r_b, n_b;
    edf_pkg::t_job   r_best, n_best;
    edf_pkg::t_job   r_run, n_run;
    logic            r_running, n_running;
    logic [31:0]     r_len, n_len;
    logic [31:0]     r_now, n_now;
    logic [47:0]     r_wait, n_wait, r_turn, n_turn;
    logic [31:0]     r_done, n_done, r_drop, n_drop;

    logic            r_ov, n_ov;
    logic [2:0]      r_kind, n_kind;
    logic [15:0]     r_pid, n_pid;
    logic [31:0]     r_s, n_s, r_e, n_e;
    logic [47:0]     r_owait, n_owait, r_oturn, n_oturn;
    logic [31:0]     r_odone, n_odone, r_odrop, n_odrop;
    logic            r_last, n_last;

    edf_pkg::t_job     w_job [QUEUE_DEPTH];
    edf_pkg::t_cell_ctl w_ctl [QUEUE_DEPTH];
    edf_pkg::t_job     w_push;
    logic              do_push, do_remove, emit, can_emit, s_acc, infeas;
    logic [15:0]       burst, rem_dec;
    logic [31:0]       el;

    // queue cells
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        edf_pkg::t_job w_next;
        if (g < QUEUE_DEPTH - 1) begin : g_mid
            assign w_next = w_job[g+1];
        end else begin : g_top
            assign w_next = w_job[g];
        end
        assign w_ctl[g].shift = do_remove && (IW'(g) >= r_b) && (g < QUEUE_DEPTH - 1);
        assign w_ctl[g].load  = do_push && (r_count[IW-1:0] == IW'(g));
        edf_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl[g]),
            .i_push (w_push),
            .i_next (w_next),
            .o_job  (w_job[g])
        );
    end

    assign can_emit      = !r_ov || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && can_emit;
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign burst         = (s_axis_tdata[31:16] == 16'd0) ? 16'd1 : s_axis_tdata[31:16];
    assign rem_dec       = r_run.remaining - 16'd1;
    assign el            = r_now + 32'd1 - r_run.arrived;
    assign infeas        = (r_now >= r_run.deadline) ||
                           (({1'b0, r_now} + {17'b0, r_run.remaining}) >
                            {1'b0, r_run.deadline});

    always_comb begin
        n_state = r_state;   n_count = r_count;   n_i = r_i;   n_b = r_b;
        n_best = r_best;     n_run = r_run;       n_running = r_running;
        n_len = r_len;       n_now = r_now;
        n_wait = r_wait;     n_turn = r_turn;     n_done = r_done;  n_drop = r_drop;
        n_ov = r_ov && !m_axis_tready;
        n_kind = r_kind;     n_pid = r_pid;       n_s = r_s;   n_e = r_e;
        n_last = r_last;
        emit = 1'b0;  do_push = 1'b0;  do_remove = 1'b0;
        w_push = r_run;

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    if (!s_axis_tuser[0]) begin
                        emit = 1'b1;
                        n_pid = s_axis_tdata[15:0];
                        n_s = r_now;  n_e = 32'd0;  n_last = 1'b1;
                        if (r_count >= DEPTH_C) begin
                            n_kind = edf_pkg::EV_DROP;
                        end else begin
                            n_kind = edf_pkg::EV_ACCEPT;
                            do_push = 1'b1;
                            w_push = '{pid: s_axis_tdata[15:0], deadline: s_axis_tdata[63:32],
                                       arrived: r_now, remaining: burst, full_burst: burst};
                            n_count = r_count + CW'(1);
                        end
                    end else if (r_count != '0) begin
                        n_i = CW'(1);  n_b = '0;  n_best = w_job[0];  n_state = S_SCAN;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_SCAN: begin
                if (r_i < r_count) begin
                    if ((w_job[r_i[IW-1:0]].deadline < r_best.deadline) ||
                        ((w_job[r_i[IW-1:0]].deadline == r_best.deadline) &&
                         (w_job[r_i[IW-1:0]].pid < r_best.pid))) begin
                        n_best = w_job[r_i[IW-1:0]];
                        n_b = r_i[IW-1:0];
                    end
                    n_i = r_i + CW'(1);
                end else begin
                    n_state = S_TAKE;
                end
            end
            S_TAKE: begin
                if (r_running && (r_best.pid == r_run.pid)) begin
                    do_remove = 1'b1;  n_count = r_count - CW'(1);  n_state = S_CHECK;
                end else if (r_running) begin
                    if (can_emit) begin
                        emit = 1'b1;  n_kind = edf_pkg::EV_PREEMPT;  n_pid = r_run.pid;
                        n_s = r_now - r_len;  n_e = r_now - 32'd1;  n_last = 1'b0;
                        n_run = r_best;  n_len = 32'd0;
                        do_remove = 1'b1;  n_count = r_count - CW'(1);  n_state = S_CHECK;
                    end
                end else begin
                    n_run = r_best;  n_len = 32'd0;  n_running = 1'b1;
                    do_remove = 1'b1;  n_count = r_count - CW'(1);  n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_running && infeas) begin
                    if (can_emit) begin
                        n_drop = inc32(r_drop);
                        n_wait = sat48(r_wait, r_now - r_run.arrived);
                        n_turn = sat48(r_turn, r_now - r_run.arrived);
                        emit = 1'b1;  n_kind = edf_pkg::EV_REMOVED;  n_pid = r_run.pid;
                        n_s = r_now;  n_e = 32'd0;  n_last = 1'b0;
                        n_running = 1'b0;
                        if (r_count != '0) begin
                            n_i = CW'(1);  n_b = '0;  n_best = w_job[0];  n_state = S_SCAN;
                        end
                    end
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_running) begin
                    n_state = S_SUM;
                end else if (rem_dec == 16'd0) begin
                    if (can_emit) begin
                        n_len = r_len + 32'd1;  n_run.remaining = rem_dec;
                        n_done = inc32(r_done);
                        if (el >= {16'b0, r_run.full_burst}) begin
                            n_wait = sat48(r_wait, el - {16'b0, r_run.full_burst});
                        end
                        n_turn = sat48(r_turn, r_now - r_run.arrived);
                        emit = 1'b1;  n_kind = edf_pkg::EV_FINISH;  n_pid = r_run.pid;
                        n_s = r_now - r_len;  n_e = r_now;  n_last = 1'b0;
                        n_running = 1'b0;  n_state = S_SUM;
                    end
                end else begin
                    n_len = r_len + 32'd1;  n_run.remaining = rem_dec;
                    w_push = r_run;  w_push.remaining = rem_dec;
                    if (r_count < DEPTH_C) begin
                        do_push = 1'b1;  n_count = r_count + CW'(1);
                    end
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (can_emit) begin
                    emit = 1'b1;  n_kind = edf_pkg::EV_SUMMARY;  n_pid = 16'd0;
                    n_s = r_now;  n_e = r_now;  n_last = 1'b1;
                    n_now = r_now + 32'd1;  n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // results carry totals after their own event
        n_owait = r_owait;  n_oturn = r_oturn;  n_odone = r_odone;  n_odrop = r_odrop;
        if (emit) begin
            n_ov = 1'b1;
            n_owait = n_wait;  n_oturn = n_turn;  n_odone = n_done;  n_odrop = n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;  r_count <= '0;  r_running <= 1'b0;  r_ov <= 1'b0;
            r_run <= '0;  r_len <= '0;  r_now <= '0;
            r_wait <= '0;  r_turn <= '0;  r_done <= '0;  r_drop <= '0;
        end else begin
            r_state <= n_state;  r_count <= n_count;  r_running <= n_running;
            r_ov <= n_ov;  r_run <= n_run;  r_len <= n_len;  r_now <= n_now;
            r_wait <= n_wait;  r_turn <= n_turn;  r_done <= n_done;  r_drop <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i;  r_b <= n_b;  r_best <= n_best;
        r_kind <= n_kind;  r_pid <= n_pid;  r_s <= n_s;  r_e <= n_e;  r_last <= n_last;
        r_owait <= n_owait;  r_oturn <= n_oturn;  r_odone <= n_odone;  r_odrop <= n_odrop;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_kind;
    assign m_axis_tlast  = r_last;
    assign m_axis_tdata  = {r_odrop, r_odone, r_oturn, r_owait, r_e, r_s, r_pid};

endmodule

`default_nettype wire

### hdl/edf_sched_chk.sv
// ----------------------------------------------------------------------------
// edf_sched_chk
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "edf_deadline_scheduler_core_assert.svh"

module edf_sched_chk (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         s_axis_tvalid,
    input wire         s_axis_tready,
    input wire [63:0]  s_axis_tdata,
    input wire [0:0]   s_axis_tuser,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire [239:0] m_axis_tdata,
    input wire [2:0]   m_axis_tuser,
    input wire         m_axis_tlast
);

    logic w_data_seen;
    assign w_data_seen = |s_axis_tdata;

    `EDF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
    `EDF_ASSERT_NEXT(a_tick_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser[0] && (w_data_seen || !w_data_seen), !s_axis_tready, "tick accepted while sequencer free")
    `EDF_ASSERT_NOW(a_last_kind, m_axis_tvalid && m_axis_tlast, (m_axis_tuser == edf_pkg::EV_SUMMARY) || (m_axis_tuser == edf_pkg::EV_ACCEPT) || (m_axis_tuser == edf_pkg::EV_DROP), "tlast on inner result")
    `EDF_ASSERT_NOW(a_sum_last, m_axis_tvalid && (m_axis_tuser == edf_pkg::EV_SUMMARY), m_axis_tlast && (m_axis_tdata[47:16] == m_axis_tdata[79:48]), "bad tick summary")

endmodule

bind edf_deadline_scheduler_core edf_sched_chk u_edf_sched_chk (.*);

`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the earliest-deadline-first scheduler core. A short
// table of directed arrivals and ticks is followed by random job streams. Every
// accepted item runs through a local scheduler model, and each output item is
// compared field by field with the oldest predicted event.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
    localparam logic MODE_ARRIVE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    // one predicted output event
    typedef struct {
        edf_pkg::t_event_kind kind;
        logic [15:0] pid;
        logic [31:0] span_s;
        logic [31:0] span_e;
        logic [47:0] wait_tot;
        logic [47:0] turn_tot;
        logic [31:0] done_cnt;
        logic [31:0] drop_cnt;
        logic        last;
    } t_sched_event;

    // directed stimulus row; chk marks a row whose first event kind is typed in
    typedef struct {
        logic        mode;
        logic [15:0] pid;
        logic [15:0] burst;
        logic [31:0] due;
        logic        chk;
        edf_pkg::t_event_kind kind;
    } t_stim_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata;   // job_id, burst_len, due_tick from bit 0 up
    logic [0:0]   s_axis_tuser;   // mode
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [239:0] m_axis_tdata;   // pid, span start/end, wait, turn, done, dropped
    logic [2:0]   m_axis_tuser;   // event kind
    logic         m_axis_tlast;

    edf_deadline_scheduler_core #(.QUEUE_DEPTH(DEPTH)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- model
    edf_pkg::t_job job_q [DEPTH];
    int          job_cnt;
    edf_pkg::t_job cur;
    logic        busy;
    logic [31:0] seg_len;
    logic [31:0] tick_now;
    logic [47:0] wait_acc, turn_acc;
    logic [31:0] fin_acc, rem_acc;

    t_sched_event event_q[$];
    edf_pkg::t_event_kind first_kind;
    int           n_fail;
    int           n_items;
    logic         hold_req;

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b,
                                            logic [63:0] top);
        if (b >= top - a) return top;
        return a + b;
    endfunction

    function automatic void post_event(edf_pkg::t_event_kind k, logic [15:0] pid,
                                       logic [31:0] s, logic [31:0] e);
        t_sched_event ev;
        ev.kind = k;
        ev.pid = pid;
        ev.span_s = s;
        ev.span_e = e;
        ev.wait_tot = wait_acc;
        ev.turn_tot = turn_acc;
        ev.done_cnt = fin_acc;
        ev.drop_cnt = rem_acc;
        ev.last = 1'b0;
        event_q.push_back(ev);
    endfunction

    // earliest deadline, lower pid on ties, lower slot on full ties
    function automatic int earliest_slot();
        int b;
        b = 0;
        for (int i = 1; i < job_cnt; i++)
            if (job_q[i].deadline < job_q[b].deadline ||
                (job_q[i].deadline == job_q[b].deadline && job_q[i].pid < job_q[b].pid))
                b = i;
        return b;
    endfunction

    function automatic void drop_slot(int k);
        for (int i = k; i + 1 < job_cnt; i++) job_q[i] = job_q[i + 1];
        if (job_cnt > 0) job_cnt--;
    endfunction

    function automatic void take_slot(int k);
        cur = job_q[k];
        drop_slot(k);
    endfunction

    function automatic void sched_step(logic mode, logic [15:0] pid,
                                       logic [15:0] burst, logic [31:0] due);
        int          n0;
        int          b;
        logic [31:0] now, d, el;
        edf_pkg::t_job nj;
        n0 = event_q.size();
        now = tick_now;
        if (mode == MODE_ARRIVE) begin
            if (burst == 16'd0) burst = 16'd1;
            if (job_cnt >= DEPTH) begin
                post_event(edf_pkg::EV_DROP, pid, now, 32'd0);
            end else begin
                nj.pid = pid;
                nj.deadline = due;
                nj.arrived = now;
                nj.remaining = burst;
                nj.full_burst = burst;
                job_q[job_cnt] = nj;
                job_cnt++;
                post_event(edf_pkg::EV_ACCEPT, pid, now, 32'd0);
            end
        end else begin
            if (busy) begin
                if (job_cnt > 0) begin
                    b = earliest_slot();
                    if (job_q[b].pid != cur.pid) begin
                        post_event(edf_pkg::EV_PREEMPT, cur.pid, now - seg_len,
                                   now - 32'd1);
                        take_slot(b);
                        seg_len = 0;
                    end else begin
                        drop_slot(b);
                    end
                end
            end else if (job_cnt > 0) begin
                seg_len = 0;
                take_slot(earliest_slot());
                busy = 1'b1;
            end
            // infeasible jobs leave, the next pick is tried at once
            while (busy && (now >= cur.deadline ||
                   ({1'b0, now} + {17'd0, cur.remaining}) > {1'b0, cur.deadline})) begin
                d = now - cur.arrived;
                busy = 1'b0;
                rem_acc = 32'(sat_add(rem_acc, 1, MAX32));
                wait_acc = 48'(sat_add(wait_acc, d, MAX48));
                turn_acc = 48'(sat_add(turn_acc, d, MAX48));
                post_event(edf_pkg::EV_REMOVED, cur.pid, now, 32'd0);
                if (job_cnt > 0) begin
                    seg_len = 0;
                    take_slot(earliest_slot());
                    busy = 1'b1;
                end
            end
            if (busy) begin
                seg_len = seg_len + 1;
                cur.remaining = cur.remaining - 16'd1;
                if (cur.remaining == 16'd0) begin
                    el = now + 32'd1 - cur.arrived;
                    fin_acc = 32'(sat_add(fin_acc, 1, MAX32));
                    if (el >= cur.full_burst)
                        wait_acc = 48'(sat_add(wait_acc, el - cur.full_burst, MAX48));
                    turn_acc = 48'(sat_add(turn_acc, now - cur.arrived, MAX48));
                    post_event(edf_pkg::EV_FINISH, cur.pid, now - seg_len + 32'd1, now);
                    busy = 1'b0;
                end else if (job_cnt < DEPTH) begin
                    job_q[job_cnt] = cur;
                    job_cnt++;
                end
            end
            tick_now = now + 32'd1;
            post_event(edf_pkg::EV_SUMMARY, 16'd0, now, now);
        end
        event_q[event_q.size() - 1].last = 1'b1;
        first_kind = event_q[n0].kind;
    endfunction

    task automatic note_fail(string msg);
        n_fail++;
        if (n_fail <= 10) $display("mismatch: %s", msg);
    endtask

    // ---------------------------------------------------------------- driving
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one item, wait for the handshake, then predict its events
    task automatic send_item(logic mode, logic [15:0] pid, logic [15:0] burst,
                             logic [31:0] due);
        int g;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= {due, burst, pid};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sched_step(mode, pid, burst, due);
        n_items++;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic send_random_job();
        logic [15:0] pid, burst;
        logic [31:0] due;
        int          r;
        pid = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
        r = $urandom_range(0, 9);
        burst = (r == 0) ? 16'($urandom) : 16'($urandom_range(1, 8));
        r = $urandom_range(0, 9);
        if (r < 6)
            due = tick_now + burst + $urandom_range(0, 40);
        else if (r < 8)
            due = tick_now + $urandom_range(0, 3);
        else
            due = $urandom;
        send_item(MODE_ARRIVE, pid, burst, due);
    endtask

    t_stim_row rows[] = '{
        '{MODE_TICK,   16'd0,     16'd0,     32'd0,         1'b1, edf_pkg::EV_SUMMARY},
        '{MODE_ARRIVE, 16'd0,     16'd0,     32'd5,         1'b1, edf_pkg::EV_ACCEPT},
        '{MODE_ARRIVE, 16'hFFFF,  16'hFFFF,  32'hFFFF_FFFF, 1'b1, edf_pkg::EV_ACCEPT},
        '{MODE_ARRIVE, 16'd3,     16'd2,     32'd0,         1'b1, edf_pkg::EV_ACCEPT},
        '{MODE_TICK,   16'd0,     16'd0,     32'd0,         1'b1, edf_pkg::EV_REMOVED},
        '{MODE_TICK,   16'd0,     16'd0,     32'd0,         1'b0, edf_pkg::EV_SUMMARY},
        '{MODE_ARRIVE, 16'd7,     16'd3,     32'd100,       1'b0, edf_pkg::EV_ACCEPT},
        '{MODE_ARRIVE, 16'd5,     16'd3,     32'd100,       1'b0, edf_pkg::EV_ACCEPT},
        '{MODE_TICK,   16'hAAAA,  16'h5555,  32'h5555_AAAA, 1'b0, edf_pkg::EV_SUMMARY},
        '{MODE_TICK,   16'd0,     16'd0,     32'd0,         1'b0, edf_pkg::EV_SUMMARY},
        '{MODE_ARRIVE, 16'd1,     16'd1,     32'd8,         1'b0, edf_pkg::EV_ACCEPT},
        '{MODE_TICK,   16'd0,     16'd0,     32'd0,         1'b0, edf_pkg::EV_SUMMARY},
        '{MODE_TICK,   16'd0,     16'd0,     32'd0,         1'b0, edf_pkg::EV_SUMMARY},
        '{MODE_ARRIVE, 16'd9,     16'd65535, 32'd20,        1'b1, edf_pkg::EV_ACCEPT},
        '{MODE_TICK,   16'd0,     16'd0,     32'd0,         1'b0, edf_pkg::EV_SUMMARY}
    };

    initial begin
        int n_rand;
        int n_arr;
        logic paused;
        job_cnt = 0; busy = 1'b0; seg_len = 0; tick_now = 0;
        wait_acc = 0; turn_acc = 0; fin_acc = 0; rem_acc = 0;
        n_fail = 0; n_items = 0; hold_req = 1'b0;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            send_item(rows[i].mode, rows[i].pid, rows[i].burst, rows[i].due);
            if (rows[i].chk && first_kind != rows[i].kind)
                note_fail($sformatf("row %0d first event %0d, table says %0d",
                                    i, first_kind, rows[i].kind));
        end

        // random job streams: a few arrivals, then a few ticks; now and then
        // a flood of arrivals that overruns the queue
        n_rand = 0;
        paused = 1'b0;
        while (n_rand < 95) begin
            if ($urandom_range(0, 7) == 0) n_arr = 18;
            else n_arr = $urandom_range(0, 3);
            repeat (n_arr) begin
                send_random_job();
                n_rand++;
            end
            repeat ($urandom_range(1, 4)) begin
                send_item(MODE_TICK, 16'($urandom), 16'($urandom), $urandom);
                n_rand++;
            end
            if (n_rand >= 30 && !hold_req) hold_req = 1'b1;
            // let the output side drain completely once
            if (n_rand >= 70 && !paused) begin
                paused = 1'b1;
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                while (event_q.size() != 0) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (event_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // ---------------------------------------------------------------- receiving
    // random back-pressure, plus one long hold-off so the core fills and stalls
    initial begin
        int hold_cnt;
        logic held;
        int r;
        hold_cnt = 0;
        held = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !held) begin
                held = 1'b1;
                hold_cnt = 400;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 8) hold_cnt = $urandom_range(10, 30);
                m_axis_tready <= (r >= 25);
            end
        end
    end

    // compare each accepted output item with the oldest prediction
    always @(posedge i_clk) begin
        t_sched_event ev;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (event_q.size() == 0) begin
                note_fail($sformatf("unexpected item kind %0d pid %0h",
                                    m_axis_tuser, m_axis_tdata[15:0]));
            end else begin
                ev = event_q.pop_front();
                if (m_axis_tuser != ev.kind ||
                    m_axis_tdata[15:0] != ev.pid ||
                    m_axis_tdata[47:16] != ev.span_s ||
                    m_axis_tdata[79:48] != ev.span_e ||
                    m_axis_tdata[127:80] != ev.wait_tot ||
                    m_axis_tdata[175:128] != ev.turn_tot ||
                    m_axis_tdata[207:176] != ev.done_cnt ||
                    m_axis_tdata[239:208] != ev.drop_cnt ||
                    m_axis_tlast != ev.last)
                    note_fail($sformatf(
                        {"exp k%0d p%0h s%0h e%0h w%0h t%0h d%0h r%0h l%0b / ",
                         "got k%0d p%0h s%0h e%0h w%0h t%0h d%0h r%0h l%0b"},
                        ev.kind, ev.pid, ev.span_s, ev.span_e, ev.wait_tot,
                        ev.turn_tot, ev.done_cnt, ev.drop_cnt, ev.last,
                        m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[47:16],
                        m_axis_tdata[79:48], m_axis_tdata[127:80],
                        m_axis_tdata[175:128], m_axis_tdata[207:176],
                        m_axis_tdata[239:208], m_axis_tlast));
            end
        end
    end

    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
